@@ rtl/core/rfrts_pkg.sv @@
// Package for the UART receive FIFO with RTS flow control.
// Holds the request codes, register indexes, field widths and register reset values.
// No dependencies.
package rfrts_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LevelW = 6;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned CfgIdxW = 1;

  // Request codes carried on req_type.
  typedef enum logic [ReqW-1:0] {
    ReqPush  = 2'd0,
    ReqPop   = 2'd1,
    ReqFlush = 2'd2,
    ReqNop   = 2'd3
  } req_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgHighWater = 1'b0,
    CfgLowWater  = 1'b1
  } cfg_idx_e;

  // Register reset values.
  localparam logic [LevelW-1:0] HighWaterReset = 6'd48;
  localparam logic [LevelW-1:0] LowWaterReset  = 6'd16;

endpackage

@@ rtl/core/rfrts_store.sv @@
// Byte store of the receive FIFO: one write port, one read port, registered read data.
// Depends on rfrts_pkg for the byte width.
module rfrts_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [AW-1:0]           wr_addr_i,
  input  logic [rfrts_pkg::ByteW-1:0] wr_data_i,
  input  logic                    rd_en_i,
  input  logic [AW-1:0]           rd_addr_i,
  output logic [rfrts_pkg::ByteW-1:0] rd_data_o
);
  import rfrts_pkg::*;

  logic [ByteW-1:0] mem_q [DEPTH];
  logic [ByteW-1:0] rd_data_q;

  // Write port; entries hold no reset value.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/rx_fifo_rts_flow_control_core.sv @@
// Top level of the UART receive FIFO with RTS flow control.
// Depends on rfrts_pkg and rfrts_store.
//
//   Channel   Handshake                  Payload
//   request   start_i, busy_o            req_type_i, rx_byte_i
//   result    done_o (one-cycle strobe)  read_data_o, read_valid_o, byte_dropped_o,
//                                        overflow_flag_o, rts_out_o, fill_count_o
//   config    cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_data_i
//
// A request is taken at any edge with start_i high; busy_o stays low, so one request
// is taken per cycle. Its result shows in the next cycle, when the registered read
// data of the byte store is ready. Pointers, RTS and the overflow flag update at the
// accepting edge; a pop reads the store at that same edge. The receiver cannot stall.
// Reset clears pointers, RTS and the overflow flag, and loads the thresholds with
// 48 and 16; the store is not cleared.
module rx_fifo_rts_flow_control_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [rfrts_pkg::ReqW-1:0]    req_type_i,
  input  logic [rfrts_pkg::ByteW-1:0]   rx_byte_i,
  output logic                          done_o,
  output logic [rfrts_pkg::ByteW-1:0]   read_data_o,
  output logic                          read_valid_o,
  output logic                          byte_dropped_o,
  output logic                          overflow_flag_o,
  output logic                          rts_out_o,
  output logic [rfrts_pkg::LevelW-1:0]  fill_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rfrts_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rfrts_pkg::LevelW-1:0]  cfg_data_i
);
  import rfrts_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CmpW = (PtrW > LevelW) ? PtrW : LevelW;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);
  localparam logic [PtrW:0]   DepthW1  = (PtrW + 1)'(DEPTH);

  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic              rts_q, rts_d, ovf_q, ovf_d;
  logic [LevelW-1:0] high_water_q, low_water_q;
  logic              done_q, valid_q, dropped_q;
  logic [ByteW-1:0]  store_rdata;
  logic              accept, full, empty;
  logic              store_we, store_re;
  logic [PtrW-1:0]   wr_next, rd_next;
  logic [CmpW-1:0]   push_count, pop_count, cur_count;
  req_e              req;

  // Held bytes for a pair of pointers, in the comparison width.
  function automatic logic [CmpW-1:0] held(input logic [PtrW-1:0] wr,
                                           input logic [PtrW-1:0] rd);
    logic [PtrW:0] diff;
    if (wr >= rd) begin
      diff = {1'b0, wr} - {1'b0, rd};
    end else begin
      diff = DepthW1 - {1'b0, rd} + {1'b0, wr};
    end
    return CmpW'(diff);
  endfunction

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign req         = req_e'(req_type_i);

  // Ring pointer arithmetic.
  assign wr_next    = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next    = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
  assign full       = (wr_next == rd_ptr_q);
  assign empty      = (wr_ptr_q == rd_ptr_q);
  assign push_count = held(wr_next, rd_ptr_q);
  assign pop_count  = empty ? '0 : held(wr_ptr_q, rd_next);
  assign cur_count  = held(wr_ptr_q, rd_ptr_q);

  // Next state of pointers and flags for the accepted request.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    rts_d    = rts_q;
    ovf_d    = ovf_q;
    store_we = 1'b0;
    store_re = 1'b0;
    if (accept) begin
      case (req)
        ReqPush: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            store_we = 1'b1;
            wr_ptr_d = wr_next;
            if (push_count >= CmpW'(high_water_q)) begin
              rts_d = 1'b1;
            end
          end
        end
        ReqPop: begin
          if (!empty) begin
            store_re = 1'b1;
            rd_ptr_d = rd_next;
          end
          if (rts_q && (pop_count < CmpW'(low_water_q))) begin
            rts_d = 1'b0;
          end
        end
        ReqFlush: begin
          wr_ptr_d = '0;
          rd_ptr_d = '0;
          rts_d    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      rts_q     <= 1'b0;
      ovf_q     <= 1'b0;
      done_q    <= 1'b0;
      valid_q   <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      rts_q     <= rts_d;
      ovf_q     <= ovf_d;
      done_q    <= accept;
      valid_q   <= store_re;
      dropped_q <= accept && (req == ReqPush) && full;
    end
  end

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_water_q <= HighWaterReset;
      low_water_q  <= LowWaterReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgHighWater: high_water_q <= cfg_data_i;
        CfgLowWater:  low_water_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rfrts_store #(
    .DEPTH(DEPTH),
    .AW   (PtrW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (store_we),
    .wr_addr_i(wr_ptr_q),
    .wr_data_i(rx_byte_i),
    .rd_en_i  (store_re),
    .rd_addr_i(rd_ptr_q),
    .rd_data_o(store_rdata)
  );

  // Result: state registers already hold the values after the request.
  assign done_o          = done_q;
  assign read_valid_o    = valid_q;
  assign read_data_o     = valid_q ? store_rdata : '0;
  assign byte_dropped_o  = dropped_q;
  assign overflow_flag_o = ovf_q;
  assign rts_out_o       = rts_q;
  assign fill_count_o    = cur_count[LevelW-1:0];

  // A dropped byte always leaves the overflow flag set.
  a_drop_sets_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && dropped_q |-> ovf_q) else $error("drop without overflow flag");

  // A result never both returns and drops a byte.
  a_valid_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(valid_q && dropped_q)) else $error("read and drop in one result");

  // Only reset clears the overflow flag.
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(ovf_q)) else $error("overflow flag cleared");

  // A flush leaves the FIFO empty with RTS low.
  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req == ReqFlush) |=> (cur_count == '0) && !rts_q)
    else $error("flush did not empty the FIFO");

  // Every request gets its result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_q) else $error("missing result strobe");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for rx_fifo_rts_flow_control_core: pushes, pops, flushes and no-ops are driven
// against a mirror of the ring buffer, RTS level and overflow flag, and every status is checked.
// Depends on rfrts_pkg and the RTL of the core.
module testbench;
  import rfrts_pkg::*;

  localparam int unsigned FifoDepth = 64;
  localparam int unsigned Phases = 3;
  localparam int unsigned Segments = 5;
  localparam int unsigned SegmentItems = 100;

  // Threshold settings, one per segment; the last segment picks random values.
  localparam logic [LevelW-1:0] HighSet [Segments] = '{6'd48, 6'd1, 6'd63, 6'd0, 6'd32};
  localparam logic [LevelW-1:0] LowSet  [Segments] = '{6'd16, 6'd0, 6'd63, 6'd63, 6'd8};

  // Status reported for one request, in port order.
  typedef struct packed {
    logic [ByteW-1:0]  read_data;
    logic              read_valid;
    logic              byte_dropped;
    logic              overflow_flag;
    logic              rts_out;
    logic [LevelW-1:0] fill_count;
  } fifo_status_t;

  // Mirror of the receive FIFO. It predicts the status of every accepted request
  // and checks the statuses the core reports against them in order.
  class rx_fifo_mirror;
    logic [ByteW-1:0]  byte_ram [FifoDepth];
    logic [LevelW-1:0] wr_ptr;
    logic [LevelW-1:0] rd_ptr;
    logic [LevelW-1:0] high_water;
    logic [LevelW-1:0] low_water;
    logic              rts_level;
    logic              overflow_seen;
    fifo_status_t      pending_status [$];
    int unsigned       mismatches;
    int unsigned       statuses_checked;
    int unsigned       pushes;
    int unsigned       drops;
    int unsigned       good_pops;
    int unsigned       empty_pops;
    int unsigned       flushes;
    int unsigned       nops;

    function new();
      wr_ptr = '0;
      rd_ptr = '0;
      high_water = HighWaterReset;
      low_water = LowWaterReset;
      rts_level = 1'b0;
      overflow_seen = 1'b0;
      mismatches = 0;
      statuses_checked = 0;
      pushes = 0;
      drops = 0;
      good_pops = 0;
      empty_pops = 0;
      flushes = 0;
      nops = 0;
    endfunction

    function void set_threshold(cfg_idx_e idx, logic [LevelW-1:0] value);
      if (idx == CfgHighWater) begin
        high_water = value;
      end else begin
        low_water = value;
      end
    endfunction

    // Pointers are as wide as the slot index, so the difference wraps by itself.
    function logic [LevelW-1:0] held();
      return wr_ptr - rd_ptr;
    endfunction

    function void note_request(req_e req, logic [ByteW-1:0] rx_byte);
      fifo_status_t      want;
      logic [LevelW-1:0] next_wr;
      want = '0;
      next_wr = wr_ptr + 1'b1;
      case (req)
        ReqPush: begin
          pushes++;
          // A full buffer drops the byte and leaves RTS alone.
          if (next_wr == rd_ptr) begin
            overflow_seen = 1'b1;
            want.byte_dropped = 1'b1;
            drops++;
          end else begin
            byte_ram[wr_ptr] = rx_byte;
            wr_ptr = next_wr;
            if (held() >= high_water) rts_level = 1'b1;
          end
        end
        ReqPop: begin
          if (rd_ptr != wr_ptr) begin
            want.read_data = byte_ram[rd_ptr];
            want.read_valid = 1'b1;
            rd_ptr = rd_ptr + 1'b1;
            good_pops++;
          end else begin
            empty_pops++;
          end
          // The low-water check runs even when the pop found nothing.
          if (rts_level && held() < low_water) rts_level = 1'b0;
        end
        ReqFlush: begin
          wr_ptr = '0;
          rd_ptr = '0;
          rts_level = 1'b0;
          flushes++;
        end
        default: begin
          nops++;
        end
      endcase
      want.overflow_flag = overflow_seen;
      want.rts_out = rts_level;
      want.fill_count = held();
      pending_status.push_back(want);
    endfunction

    function void check_status(fifo_status_t got);
      fifo_status_t want;
      if (pending_status.size() == 0) begin
        $error("status reported with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_status.pop_front();
      statuses_checked++;
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
        mismatches++;
      end
      if (got.read_valid !== want.read_valid) begin
        $error("read_valid: expected %0b, got %0b", want.read_valid, got.read_valid);
        mismatches++;
      end
      if (got.byte_dropped !== want.byte_dropped) begin
        $error("byte_dropped: expected %0b, got %0b", want.byte_dropped, got.byte_dropped);
        mismatches++;
      end
      if (got.overflow_flag !== want.overflow_flag) begin
        $error("overflow_flag: expected %0b, got %0b", want.overflow_flag, got.overflow_flag);
        mismatches++;
      end
      if (got.rts_out !== want.rts_out) begin
        $error("rts_out: expected %0b, got %0b", want.rts_out, got.rts_out);
        mismatches++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [ReqW-1:0]   req_type_i;
  logic [ByteW-1:0]  rx_byte_i;
  logic              done_o;
  logic [ByteW-1:0]  read_data_o;
  logic              read_valid_o;
  logic              byte_dropped_o;
  logic              overflow_flag_o;
  logic              rts_out_o;
  logic [LevelW-1:0] fill_count_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [LevelW-1:0] cfg_data_i;

  rx_fifo_rts_flow_control_core #(
    .DEPTH(FifoDepth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .rx_byte_i      (rx_byte_i),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .read_valid_o   (read_valid_o),
    .byte_dropped_o (byte_dropped_o),
    .overflow_flag_o(overflow_flag_o),
    .rts_out_o      (rts_out_o),
    .fill_count_o   (fill_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  rx_fifo_mirror fifo_mirror = new();

  // Free-running clock, 12 ns period.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Every strobed status is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      fifo_mirror.check_status(fifo_status_t'({read_data_o, read_valid_o, byte_dropped_o,
                                               overflow_flag_o, rts_out_o, fill_count_o}));
    end
  end

  // Issue one request and wait until the core takes it.
  task automatic send_request(req_e req, logic [ByteW-1:0] rx_byte);
    start_i <= 1'b1;
    req_type_i <= req;
    rx_byte_i <= rx_byte;
    do @(posedge clk_i); while (busy_o);
    fifo_mirror.note_request(req, rx_byte);
  endtask

  // Random idle cycles between requests.
  task automatic sender_gap(int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted status has been reported.
  task automatic drain_statuses();
    start_i <= 1'b0;
    while (fifo_mirror.pending_status.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_threshold(cfg_idx_e idx, logic [LevelW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    fifo_mirror.set_threshold(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random traffic in bursts that lean toward filling, balancing or draining,
  // so the buffer regularly runs full and empty under each threshold setting.
  task automatic random_segment(int unsigned n_items, int unsigned idle_pct);
    int unsigned burst_left;
    int unsigned push_pct;
    int unsigned flush_pct;
    int unsigned pick;
    req_e        req;
    burst_left = 0;
    push_pct = 50;
    flush_pct = 2;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(120, 30);
        case ($urandom_range(2))
          0: push_pct = 88;
          1: push_pct = 50;
          default: push_pct = 15;
        endcase
        flush_pct = (push_pct == 88) ? 0 : 2;
      end
      burst_left--;
      pick = $urandom_range(99);
      if (pick < flush_pct) begin
        req = ReqFlush;
      end else if (pick < flush_pct + 2) begin
        req = ReqNop;
      end else if (pick < flush_pct + 2 + push_pct) begin
        req = ReqPush;
      end else begin
        req = ReqPop;
      end
      send_request(req, ByteW'($urandom));
      if ($urandom_range(199) == 0) begin
        drain_statuses();
      end else begin
        sender_gap(idle_pct);
      end
    end
  endtask

  // Main sequence: reset, directed requests, then three idle regimes.
  initial begin
    int unsigned idle_pct;
    logic [LevelW-1:0] high_value;
    logic [LevelW-1:0] low_value;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    req_type_i <= ReqNop;
    rx_byte_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgHighWater;
    cfg_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests under the reset thresholds: byte extremes, pops down to
    // an empty buffer, the unused request code, and a flush followed by a pop.
    send_request(ReqPush, 8'h00);
    send_request(ReqPush, 8'hFF);
    send_request(ReqPush, 8'hA5);
    sender_gap(27);
    send_request(ReqPush, 8'h5A);
    send_request(ReqPop, 8'h00);
    send_request(ReqPop, 8'hFF);
    send_request(ReqPop, 8'h00);
    send_request(ReqPop, 8'h00);
    send_request(ReqPop, 8'h00);
    send_request(ReqNop, 8'hFF);
    send_request(ReqPush, 8'h3C);
    sender_gap(27);
    send_request(ReqPush, 8'hC3);
    send_request(ReqFlush, 8'h77);
    send_request(ReqPop, 8'h00);
    send_request(ReqPush, 8'h81);
    send_request(ReqPop, 8'h00);
    send_request(ReqNop, 8'h00);
    drain_statuses();

    for (int unsigned phase = 0; phase < Phases; phase++) begin
      idle_pct = (phase == 0) ? 27 : (phase == 1) ? 86 : 0;
      for (int unsigned seg = 0; seg < Segments; seg++) begin
        if (seg == Segments - 1) begin
          high_value = LevelW'($urandom_range(63));
          low_value = LevelW'($urandom_range(63));
        end else begin
          high_value = HighSet[seg];
          low_value = LowSet[seg];
        end
        write_threshold(CfgHighWater, high_value);
        write_threshold(CfgLowWater, low_value);
        random_segment(SegmentItems, idle_pct);
        drain_statuses();
      end
    end

    repeat (4) @(posedge clk_i);
    $display("Checked %0d statuses: %0d pushes (%0d dropped), %0d pops with data, %0d empty,",
             fifo_mirror.statuses_checked, fifo_mirror.pushes, fifo_mirror.drops,
             fifo_mirror.good_pops, fifo_mirror.empty_pops);
    $display("%0d flushes and %0d no-ops over %0d threshold settings in three idle regimes.",
             fifo_mirror.flushes, fifo_mirror.nops, Phases * Segments);
    if (fifo_mirror.mismatches == 0) begin
      $display("rx_fifo_rts_flow_control_core test passed");
    end else begin
      $display("rx_fifo_rts_flow_control_core test failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("rx_fifo_rts_flow_control_core test failed");
    $finish;
  end

endmodule
